// ----- sv/assert_macros.svh -----
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies a delayed consequent
`define ASSERT_IMP2(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/yuvrgb_pkg.sv -----
// package: word types, coefficients and the shift and clamp function
package yuvrgb_pkg;

  localparam int SumW = 18;

  localparam logic signed [SumW-1:0] COEF_RV = 18'sd359;
  localparam logic signed [SumW-1:0] COEF_GU = 18'sd88;
  localparam logic signed [SumW-1:0] COEF_GV = 18'sd183;
  localparam logic signed [SumW-1:0] COEF_BU = 18'sd454;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic       frame_end_out;
  } out_word_t;

  // floor shift by 8, then clamp to 0..255
  function automatic logic [7:0] shift_clamp(input logic signed [SumW-1:0] sum);
    logic signed [SumW-9:0] q;
    q = sum[SumW-1:8];
    if (q[SumW-9]) begin
      return 8'h00;
    end else if (q[SumW-10:8] != '0) begin
      return 8'hff;
    end else begin
      return q[7:0];
    end
  endfunction

endpackage

// ----- sv/yuvrgb_pixel.sv -----
// one pixel: luma plus shared chroma offsets to clamped rgb
module yuvrgb_pixel (
  input  logic [7:0]        luma,
  input  logic signed [7:0] u_ofs,
  input  logic signed [7:0] v_ofs,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);
  import yuvrgb_pkg::*;

  logic signed [SumW-1:0] y_w;
  logic signed [SumW-1:0] u_w;
  logic signed [SumW-1:0] v_w;
  logic signed [SumW-1:0] sum_r;
  logic signed [SumW-1:0] sum_g;
  logic signed [SumW-1:0] sum_b;

  assign y_w = {2'b00, luma, 8'h00};
  assign u_w = {{(SumW-8){u_ofs[7]}}, u_ofs};
  assign v_w = {{(SumW-8){v_ofs[7]}}, v_ofs};

  assign sum_r = y_w + COEF_RV * v_w;
  assign sum_g = y_w - COEF_GU * u_w - COEF_GV * v_w;
  assign sum_b = y_w + COEF_BU * u_w;

  assign red   = shift_clamp(sum_r);
  assign green = shift_clamp(sum_g);
  assign blue  = shift_clamp(sum_b);
endmodule

// ----- sv/yuyv_to_rgb_converter.sv -----
// top level: yuyv macropixel to two rgb888 pixels
// One macropixel word is taken on every clock edge with start high; busy is
// always low, so words may arrive back to back without gaps. Each word gives
// one result word, marked by out_valid for a single cycle, after it passes
// through the input register and the result register around the conversion
// logic. The receiver cannot stall: results must be taken as they appear.
// There is no state between words; frame_end_out copies frame_end_in.
module yuyv_to_rgb_converter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  yuvrgb_pkg::in_word_t  in_word,
  output logic                  out_valid,
  output yuvrgb_pkg::out_word_t out_word
);
  import yuvrgb_pkg::*;

  in_word_t          in_r;
  logic              in_valid_r;
  out_word_t         out_r;
  out_word_t         out_nxt;
  logic              out_valid_r;
  logic signed [7:0] u_ofs;
  logic signed [7:0] v_ofs;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start && !busy;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_word;
    end
    out_r <= out_nxt;
  end

  // subtract 128 by flipping the top bit
  assign u_ofs = {~in_r.chroma_blue[7], in_r.chroma_blue[6:0]};
  assign v_ofs = {~in_r.chroma_red[7], in_r.chroma_red[6:0]};

  yuvrgb_pixel u_first (
    .luma  (in_r.luma_first),
    .u_ofs (u_ofs),
    .v_ofs (v_ofs),
    .red   (out_nxt.first_red),
    .green (out_nxt.first_green),
    .blue  (out_nxt.first_blue)
  );

  yuvrgb_pixel u_second (
    .luma  (in_r.luma_second),
    .u_ofs (u_ofs),
    .v_ofs (v_ofs),
    .red   (out_nxt.second_red),
    .green (out_nxt.second_green),
    .blue  (out_nxt.second_blue)
  );

  assign out_nxt.frame_end_out = in_r.frame_end_in;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;
endmodule

// ----- sv/yuvrgb_checker.sv -----
// checker on the converter ports, bound to the top level
`include "assert_macros.svh"

module yuvrgb_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input yuvrgb_pkg::in_word_t  in_word,
  input logic                  out_valid,
  input yuvrgb_pkg::out_word_t out_word
);
  import yuvrgb_pkg::*;

  logic accept;
  logic gray;

  assign accept = start && !busy;
  assign gray   = in_word.chroma_blue == 8'd128 && in_word.chroma_red == 8'd128;

  `ASSERT_IMP2(a_result_follows, clk, rst_n, accept, out_valid)
  `ASSERT_IMP(a_no_invented, clk, rst_n, out_valid, $past(accept, 2))
  `ASSERT_IMP2(a_frame_end, clk, rst_n, accept, out_word.frame_end_out == $past(in_word.frame_end_in, 2))
  `ASSERT_IMP2(a_gray_passes, clk, rst_n, accept && gray, out_word.first_red == $past(in_word.luma_first, 2) && out_word.second_blue == $past(in_word.luma_second, 2))
endmodule

bind yuyv_to_rgb_converter yuvrgb_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);
